FILE: sv/i2c_rts_pkg.sv
// Shared types and codes for the I2C register transaction sequencer.
package i2c_rts_pkg;

  // Input item kinds.
  typedef enum logic [1:0] {
    REQ_CMD  = 2'd0,
    REQ_WDAT = 2'd1,
    REQ_RESP = 2'd2,
    REQ_TICK = 2'd3
  } req_kind_t;

  // Bus response kinds.
  typedef enum logic [1:0] {
    RESP_START = 2'd0,
    RESP_ACK   = 2'd1,
    RESP_NACK  = 2'd2,
    RESP_RX    = 2'd3
  } resp_kind_t;

  // Bus actions.
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_SEND  = 3'd2;
  localparam logic [2:0] ACT_RECV  = 3'd3;
  localparam logic [2:0] ACT_STOP  = 3'd4;
  localparam logic [2:0] ACT_REQ   = 3'd5;

  // Completion status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NACK    = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_BADLEN  = 2'd3;

  // Reset value of the timeout register.
  localparam logic [7:0] TIMEOUT_RESET = 8'd5;

  // One input item.
  typedef struct packed {
    logic [1:0] req_type;
    logic       cmd_read;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] wr_byte;
    logic [1:0] resp_kind;
    logic [7:0] rx_byte;
    logic       bus_busy;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       rx_ack;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       done_res;
    logic [1:0] status;
  } result_t;

endpackage

FILE: sv/i2c_register_transaction_sequencer.sv
// Top level of the I2C register transaction sequencer.
// An accepted item is held in the input register; its result is registered in the result register as the item moves on.
// Throughput: one item per cycle while back pressure does not hold the result register.
// Items that cause no result leave no output; back pressure stalls both registers.
// Reset (rst_n low, synchronous) returns to idle, clears all counters and valid bits,
// and sets the timeout register to 5 ticks.
module i2c_register_transaction_sequencer
  import i2c_rts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic       in_cmd_read,
  input  logic [6:0] in_dev_addr,
  input  logic [7:0] in_reg_addr,
  input  logic [7:0] in_byte_count,
  input  logic [7:0] in_wr_byte,
  input  logic [1:0] in_resp_kind,
  input  logic [7:0] in_rx_byte,
  input  logic       in_bus_busy,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_action,
  output logic [7:0] out_tx_byte,
  output logic       out_rx_ack,
  output logic       out_rd_valid,
  output logic [7:0] out_rd_data,
  output logic       out_done_res,
  output logic [1:0] out_status
);

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // Gather the input ports into one item.
  assign in_item = '{req_type:   in_req_type,
                     cmd_read:   in_cmd_read,
                     dev_addr:   in_dev_addr,
                     reg_addr:   in_reg_addr,
                     byte_count: in_byte_count,
                     wr_byte:    in_wr_byte,
                     resp_kind:  in_resp_kind,
                     rx_byte:    in_rx_byte,
                     bus_busy:   in_bus_busy};

  i2c_rts_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  i2c_rts_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  i2c_rts_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Spread the result item onto the output ports.
  assign out_action   = out_res.action;
  assign out_tx_byte  = out_res.tx_byte;
  assign out_rx_ack   = out_res.rx_ack;
  assign out_rd_valid = out_res.rd_valid;
  assign out_rd_data  = out_res.rd_data;
  assign out_done_res = out_res.done_res;
  assign out_status   = out_res.status;

endmodule

FILE: sv/i2c_rts_in_reg.sv
// Input register stage that holds one accepted item for the sequencer core.
module i2c_rts_in_reg
  import i2c_rts_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  s1_valid,
  output item_t s1_item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // The stage takes a new item when empty or when its item moves on.
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

FILE: sv/i2c_rts_core.sv
// Transaction state and next-state logic of the sequencer, one item per cycle while advance is high.
module i2c_rts_core
  import i2c_rts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       advance,
  input  item_t      item,
  output logic       res_valid,
  output result_t    res
);

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_WAIT_FREE = 4'd1,
    PH_START1    = 4'd2,
    PH_ADDR_W    = 4'd3,
    PH_REG       = 4'd4,
    PH_WANT_DATA = 4'd5,
    PH_DATA_W    = 4'd6,
    PH_START2    = 4'd7,
    PH_ADDR_R    = 4'd8,
    PH_RX        = 4'd9
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [6:0] target_addr_r, target_addr_nxt;
  logic [7:0] pointer_byte_r, pointer_byte_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic       is_read_r, is_read_nxt;
  logic [7:0] idle_ticks_r, idle_ticks_nxt;
  logic [7:0] timeout_r;
  logic [7:0] idle_inc;
  logic [7:0] left_dec;

  assign idle_inc = (idle_ticks_r == 8'hFF) ? idle_ticks_r : idle_ticks_r + 8'd1;
  assign left_dec = bytes_left_r - 8'd1;

  // Next state and result for the item in the input register.
  always_comb begin
    phase_nxt        = phase_r;
    target_addr_nxt  = target_addr_r;
    pointer_byte_nxt = pointer_byte_r;
    bytes_left_nxt   = bytes_left_r;
    is_read_nxt      = is_read_r;
    idle_ticks_nxt   = idle_ticks_r;
    res_valid        = 1'b0;
    res              = '0;
    case (req_kind_t'(item.req_type))
      REQ_CMD: begin
        if (phase_r == PH_IDLE) begin
          is_read_nxt      = item.cmd_read;
          target_addr_nxt  = item.dev_addr;
          pointer_byte_nxt = item.reg_addr;
          bytes_left_nxt   = item.byte_count;
          idle_ticks_nxt   = 8'd0;
          if (item.cmd_read && item.byte_count == 8'd0) begin
            res_valid    = 1'b1;
            res.done_res = 1'b1;
            res.status   = ST_BADLEN;
          end else if (item.bus_busy) begin
            phase_nxt = PH_WAIT_FREE;
          end else begin
            phase_nxt  = PH_START1;
            res_valid  = 1'b1;
            res.action = ACT_START;
          end
        end
      end
      REQ_TICK: begin
        if (phase_r == PH_WAIT_FREE && !item.bus_busy) begin
          phase_nxt      = PH_START1;
          idle_ticks_nxt = 8'd0;
          res_valid      = 1'b1;
          res.action     = ACT_START;
        end else if (phase_r != PH_IDLE) begin
          if (idle_inc < timeout_r) begin
            idle_ticks_nxt = idle_inc;
          end else begin
            // Timed out; a wait for a free bus ends without stop.
            phase_nxt      = PH_IDLE;
            idle_ticks_nxt = 8'd0;
            res_valid      = 1'b1;
            res.done_res   = 1'b1;
            res.status     = ST_TIMEOUT;
            res.action     = (phase_r == PH_WAIT_FREE) ? ACT_NONE : ACT_STOP;
          end
        end
      end
      REQ_WDAT: begin
        if (phase_r == PH_WANT_DATA) begin
          bytes_left_nxt = left_dec;
          phase_nxt      = PH_DATA_W;
          idle_ticks_nxt = 8'd0;
          res_valid      = 1'b1;
          res.action     = ACT_SEND;
          res.tx_byte    = item.wr_byte;
        end
      end
      default: begin
        // Bus response.
        case (phase_r)
          PH_START1, PH_START2: begin
            if (resp_kind_t'(item.resp_kind) == RESP_START) begin
              phase_nxt      = (phase_r == PH_START1) ? PH_ADDR_W : PH_ADDR_R;
              idle_ticks_nxt = 8'd0;
              res_valid      = 1'b1;
              res.action     = ACT_SEND;
              res.tx_byte    = {target_addr_r, phase_r == PH_START2};
            end
          end
          PH_ADDR_W, PH_ADDR_R, PH_REG, PH_DATA_W: begin
            if (resp_kind_t'(item.resp_kind) == RESP_NACK) begin
              phase_nxt      = PH_IDLE;
              idle_ticks_nxt = 8'd0;
              res_valid      = 1'b1;
              res.action     = ACT_STOP;
              res.done_res   = 1'b1;
              res.status     = ST_NACK;
            end else if (resp_kind_t'(item.resp_kind) == RESP_ACK) begin
              idle_ticks_nxt = 8'd0;
              res_valid      = 1'b1;
              if (phase_r == PH_ADDR_W) begin
                phase_nxt   = PH_REG;
                res.action  = ACT_SEND;
                res.tx_byte = pointer_byte_r;
              end else if (phase_r == PH_ADDR_R) begin
                phase_nxt  = PH_RX;
                res.action = ACT_RECV;
                res.rx_ack = bytes_left_r > 8'd1;
              end else if (is_read_r) begin
                phase_nxt  = PH_START2;
                res.action = ACT_START;
              end else if (bytes_left_r == 8'd0) begin
                phase_nxt    = PH_IDLE;
                res.action   = ACT_STOP;
                res.done_res = 1'b1;
                res.status   = ST_OK;
              end else begin
                phase_nxt  = PH_WANT_DATA;
                res.action = ACT_REQ;
              end
            end
          end
          PH_RX: begin
            if (resp_kind_t'(item.resp_kind) == RESP_RX) begin
              bytes_left_nxt = left_dec;
              idle_ticks_nxt = 8'd0;
              res_valid      = 1'b1;
              res.rd_valid   = 1'b1;
              res.rd_data    = item.rx_byte;
              if (left_dec == 8'd0) begin
                // Last byte: stop and report done.
                phase_nxt    = PH_IDLE;
                res.action   = ACT_STOP;
                res.done_res = 1'b1;
                res.status   = ST_OK;
              end else begin
                res.action = ACT_RECV;
                res.rx_ack = left_dec > 8'd1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    endcase
  end

  // Control state updates only when the item moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      target_addr_r  <= 7'd0;
      pointer_byte_r <= 8'd0;
      bytes_left_r   <= 8'd0;
      is_read_r      <= 1'b0;
      idle_ticks_r   <= 8'd0;
    end else if (advance) begin
      phase_r        <= phase_nxt;
      target_addr_r  <= target_addr_nxt;
      pointer_byte_r <= pointer_byte_nxt;
      bytes_left_r   <= bytes_left_nxt;
      is_read_r      <= is_read_nxt;
      idle_ticks_r   <= idle_ticks_nxt;
    end
  end

  // Timeout register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // A finished transaction returns to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid && res.done_res) |=> (phase_r == PH_IDLE))
    else $error("done result did not return the sequencer to idle");

  // Receiving always has at least one byte left.
  a_rx_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RX) |-> (bytes_left_r != 8'd0))
    else $error("receive phase with no bytes left");

  // The tick counter is cleared whenever the sequencer sits idle.
  a_idle_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (idle_ticks_r == 8'd0))
    else $error("tick counter not clear while idle");

  // Write data is only requested in a write transaction.
  a_req_write: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid && res.action == ACT_REQ) |-> !is_read_r)
    else $error("write data requested during a read");

endmodule

FILE: sv/i2c_rts_out_reg.sv
// Result register that holds one result item until the consumer takes it.
module i2c_rts_out_reg
  import i2c_rts_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    s1_valid,
  input  logic    res_valid,
  input  result_t res,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // The held item moves on when the result register is free or drains now.
  assign advance = s1_valid && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r && !out_ready;
    if (advance) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
